/* sv/cansd_pkg.sv */
`timescale 1ns / 1ps

package cansd_pkg;

   // item selector carried on req_tuser
   typedef logic [1:0] func_type;
   localparam func_type FUNC_DECODE    = 2'd0;
   localparam func_type FUNC_WRITE_MSG = 2'd1;
   localparam func_type FUNC_WRITE_SIG = 2'd2;
   localparam func_type FUNC_UNUSED    = 2'd3;

   localparam int DEF_MAX_MESSAGES = 64;
   localparam int DEF_MAX_SIGNALS  = 16;

   localparam int ID_W     = 31;
   localparam int TOTAL_W  = 5;
   localparam int DATA_W   = 64;
   localparam int START_W  = 6;
   localparam int LENGTH_W = 7;
   localparam int GAIN_W   = 32;
   localparam int BIAS_W   = 48;
   localparam int CSR_W    = 7;
   localparam int SIGNUM_W = 4;

   // request tdata layout, lowest bit first
   localparam int REQ_MSLOT_LSB  = 0;
   localparam int REQ_SSLOT_LSB  = 6;
   localparam int REQ_ID_LSB     = 10;
   localparam int REQ_TOTAL_LSB  = 41;
   localparam int REQ_DATA_LSB   = 46;
   localparam int REQ_START_LSB  = 110;
   localparam int REQ_LENGTH_LSB = 116;
   localparam int REQ_BIG_LSB    = 123;
   localparam int REQ_GAIN_LSB   = 124;
   localparam int REQ_BIAS_LSB   = 156;
   localparam int REQ_DATA_BITS  = 208;

   // response tdata layout, lowest bit first
   localparam int RSP_SIGNUM_LSB = 0;
   localparam int RSP_RAW_LSB    = 4;
   localparam int RSP_PHYS_LSB   = 68;
   localparam int RSP_OVF_LSB    = 132;
   localparam int RSP_DATA_BITS  = 136;
   localparam int RSP_USER_BITS  = 2;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic [ID_W-1:0]    id;
   } msg_entry_type;

   typedef struct packed {
      logic [BIAS_W-1:0]   bias;
      logic [GAIN_W-1:0]   gain;
      logic                big_endian;
      logic [LENGTH_W-1:0] length;
      logic [START_W-1:0]  start;
   } sig_entry_type;

endpackage

/* sv/cansd_ram.sv */
`timescale 1ns / 1ps

module cansd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

/* sv/can_signal_decoder_core.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Contents
// req_      in         req_tvalid/req_tready  tuser: func; tdata: slots, id, data, layout
// rsp_      out        rsp_tvalid/rsp_tready  tuser: found, has_signal; tdata: signal result
// csr_      in         csr_wr_en              csr_wr_data: messages_in_use
//
// Write items (func 1, 2) and func 3 are done in their accept cycle.
// A decode: an accept step, a search that reads the message entries in use through the
// message RAM, then the none step for a result without a signal, or per signal the steps
// extract, low, high, accumulate and emit through the shared 33x32 multiplier.
// A held result stalls only the step that loads the output register; the next item is
// accepted once the last result sits there. Reset clears control state only.

module can_signal_decoder_core #(
   parameter int MAX_MESSAGES = cansd_pkg::DEF_MAX_MESSAGES,
   parameter int MAX_SIGNALS  = cansd_pkg::DEF_MAX_SIGNALS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // func
   input  logic [1:0]                             req_tuser,
   // message_slot, signal_slot, frame_id, signal_total, frame_data, field_start,
   // field_length, big_endian, gain, bias, zero pad
   input  logic [cansd_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // found, has_signal
   output logic [cansd_pkg::RSP_USER_BITS-1:0]    rsp_tuser,
   // signal_number, raw_field, physical_value, overflowed, zero pad
   output logic [cansd_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   output logic                                   rsp_tlast,
   input  logic                                   csr_wr_en,
   input  logic [cansd_pkg::CSR_W-1:0]            csr_wr_data
);

   import cansd_pkg::*;

   localparam int MSG_AW   = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
   localparam int MSG_CW   = $clog2(MAX_MESSAGES + 1);
   localparam int CMP_W    = (MSG_CW > CSR_W) ? MSG_CW : CSR_W;
   localparam int SIG_AW   = (MAX_SIGNALS > 1) ? $clog2(MAX_SIGNALS) : 1;
   localparam int SIG_DEPTH = MAX_MESSAGES * MAX_SIGNALS;
   localparam int SIG_RAW  = (SIG_DEPTH > 1) ? $clog2(SIG_DEPTH) : 1;
   localparam int CNT_W    = 7;
   localparam int PROD_W   = 65;
   localparam int ACC_W    = 98;
   localparam int MSG_ENTRY_W = $bits(msg_entry_type);
   localparam int SIG_ENTRY_W = $bits(sig_entry_type);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SEARCH  = 3'd1;
   localparam logic [2:0] ST_NONE    = 3'd2;
   localparam logic [2:0] ST_EXTRACT = 3'd3;
   localparam logic [2:0] ST_MUL_LO  = 3'd4;
   localparam logic [2:0] ST_MUL_HI  = 3'd5;
   localparam logic [2:0] ST_ACC     = 3'd6;
   localparam logic [2:0] ST_EMIT    = 3'd7;

   // request fields
   func_type            func;
   logic [5:0]          message_slot;
   logic [3:0]          signal_slot;
   logic [ID_W-1:0]     frame_id;
   logic [TOTAL_W-1:0]  signal_total;
   logic [DATA_W-1:0]   frame_data;
   sig_entry_type       sig_wr_entry;
   msg_entry_type       msg_wr_entry;

   assign func         = req_tuser;
   assign message_slot = req_tdata[REQ_MSLOT_LSB +: 6];
   assign signal_slot  = req_tdata[REQ_SSLOT_LSB +: 4];
   assign frame_id     = req_tdata[REQ_ID_LSB +: ID_W];
   assign signal_total = req_tdata[REQ_TOTAL_LSB +: TOTAL_W];
   assign frame_data   = req_tdata[REQ_DATA_LSB +: DATA_W];
   assign sig_wr_entry.start      = req_tdata[REQ_START_LSB +: START_W];
   assign sig_wr_entry.length     = req_tdata[REQ_LENGTH_LSB +: LENGTH_W];
   assign sig_wr_entry.big_endian = req_tdata[REQ_BIG_LSB];
   assign sig_wr_entry.gain       = req_tdata[REQ_GAIN_LSB +: GAIN_W];
   assign sig_wr_entry.bias       = req_tdata[REQ_BIAS_LSB +: BIAS_W];
   assign msg_wr_entry.total      = signal_total;
   assign msg_wr_entry.id         = frame_id;

   // control and datapath registers
   logic [2:0]              state_ff, state_in;
   logic [CSR_W-1:0]        in_use_ff;
   logic [MSG_CW-1:0]       srch_ff, srch_in;
   logic                    pend_ff, pend_in;
   logic [MSG_AW-1:0]       cmp_idx_ff, cmp_idx_in;
   logic [MSG_AW-1:0]       msg_ff, msg_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        sig_ff, sig_in;
   logic                    none_found_ff, none_found_in;
   logic [ID_W-1:0]         id_ff;
   logic [DATA_W-1:0]       frame_ff;
   logic [DATA_W-1:0]       raw_ff, raw_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_has_ff, rsp_last_ff, rsp_ovf_ff;
   logic [SIGNUM_W-1:0]     rsp_signum_ff;
   logic [DATA_W-1:0]       rsp_raw_ff, rsp_phys_ff;
   logic                    rsp_load;

   // memory ports
   logic                    msg_wr_en, msg_rd_en;
   logic [MSG_AW-1:0]       msg_wr_addr, msg_rd_addr;
   logic [MSG_ENTRY_W-1:0]  msg_rd_bits;
   msg_entry_type           msg_rd;
   logic                    sig_wr_en, sig_rd_en;
   logic [SIG_RAW-1:0]      sig_wr_addr, sig_rd_addr;
   logic [SIG_ENTRY_W-1:0]  sig_rd_bits;
   sig_entry_type           sig_rd;
   logic [MSG_AW-1:0]       sig_rd_msg;
   logic [SIG_AW-1:0]       sig_rd_num;

   logic                    req_accept;
   logic                    out_free;
   logic [MSG_CW-1:0]       limit;
   logic [CMP_W-1:0]        slot_wide;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign msg_rd     = msg_entry_type'(msg_rd_bits);
   assign sig_rd     = sig_entry_type'(sig_rd_bits);

   assign limit = (CMP_W'(in_use_ff) > CMP_W'(MAX_MESSAGES)) ?
                  MSG_CW'(MAX_MESSAGES) : MSG_CW'(in_use_ff);

   // table writes happen in the accept cycle
   assign slot_wide   = CMP_W'(message_slot);
   assign msg_wr_addr = slot_wide[MSG_AW-1:0];
   assign msg_wr_en   = req_accept && (func == FUNC_WRITE_MSG) &&
                        (slot_wide < CMP_W'(MAX_MESSAGES));
   assign sig_wr_en   = req_accept && (func == FUNC_WRITE_SIG) &&
                        (slot_wide < CMP_W'(MAX_MESSAGES)) &&
                        (CNT_W'(signal_slot) < CNT_W'(MAX_SIGNALS));
   assign sig_wr_addr = SIG_RAW'(SIG_RAW'(msg_wr_addr) * SIG_RAW'(MAX_SIGNALS)) +
                        SIG_RAW'(signal_slot);
   assign sig_rd_addr = SIG_RAW'(SIG_RAW'(sig_rd_msg) * SIG_RAW'(MAX_SIGNALS)) +
                        SIG_RAW'(sig_rd_num);
   assign msg_rd_addr = srch_ff[MSG_AW-1:0];

   cansd_ram #(
      .WIDTH (MSG_ENTRY_W),
      .DEPTH (MAX_MESSAGES)
   ) u_msg_ram (
      .clock      (clock),
      .wr_en      (msg_wr_en),
      .wr_addr    (msg_wr_addr),
      .wr_data    (msg_wr_entry),
      .rd_en      (msg_rd_en),
      .rd_addr    (msg_rd_addr),
      .rd_data_ff (msg_rd_bits)
   );

   cansd_ram #(
      .WIDTH (SIG_ENTRY_W),
      .DEPTH (SIG_DEPTH)
   ) u_sig_ram (
      .clock      (clock),
      .wr_en      (sig_wr_en),
      .wr_addr    (sig_wr_addr),
      .wr_data    (sig_wr_entry),
      .rd_en      (sig_rd_en),
      .rd_addr    (sig_rd_addr),
      .rd_data_ff (sig_rd_bits)
   );

   // field extraction from the signal entry
   logic [LENGTH_W-1:0] len_c;
   logic [LENGTH_W-1:0] pos_sum;
   logic [LENGTH_W-1:0] shamt;
   logic [DATA_W-1:0]   mask;
   logic [DATA_W-1:0]   extracted;

   always_comb begin
      len_c   = sig_rd.length[LENGTH_W-1] ? LENGTH_W'(DATA_W) : sig_rd.length;
      mask    = len_c[LENGTH_W-1] ? {DATA_W{1'b1}} : ~({DATA_W{1'b1}} << len_c[5:0]);
      pos_sum = LENGTH_W'(sig_rd.start) + len_c;
      if (sig_rd.big_endian) begin
         shamt = pos_sum[LENGTH_W-1] ? '0 : LENGTH_W'(DATA_W) - pos_sum;
      end else begin
         shamt = LENGTH_W'(sig_rd.start);
      end
      extracted = shamt[LENGTH_W-1] ? '0 : ((frame_ff >> shamt[5:0]) & mask);
   end

   // shared multiplier: one 32-bit half of the raw field times the signed gain
   logic signed [32:0]        mul_a;
   logic signed [GAIN_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]  mul_p;

   assign mul_a = (state_ff == ST_MUL_HI) ? $signed({1'b0, raw_ff[63:32]}) :
                                            $signed({1'b0, raw_ff[31:0]});
   assign mul_b = $signed(sig_rd.gain);
   assign mul_p = mul_a * mul_b;

   // saturation of the exact sum
   logic              sat;
   logic [DATA_W-1:0] phys;

   always_comb begin
      sat = !((acc_ff[ACC_W-1:DATA_W-1] == '0) || (acc_ff[ACC_W-1:DATA_W-1] == '1));
      if (!sat) begin
         phys = acc_ff[DATA_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         phys = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         phys = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   logic last_sig;
   assign last_sig = (sig_ff + CNT_W'(1)) == count_ff;

   always_comb begin
      state_in      = state_ff;
      srch_in       = srch_ff;
      pend_in       = pend_ff;
      cmp_idx_in    = cmp_idx_ff;
      msg_in        = msg_ff;
      count_in      = count_ff;
      sig_in        = sig_ff;
      none_found_in = none_found_ff;
      raw_in        = raw_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      msg_rd_en     = 1'b0;
      sig_rd_en     = 1'b0;
      sig_rd_msg    = msg_ff;
      sig_rd_num    = sig_ff[SIG_AW-1:0];
      rsp_load      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (func == FUNC_DECODE)) begin
               srch_in  = '0;
               pend_in  = 1'b0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (pend_ff && (msg_rd.id == id_ff)) begin
               // first match wins; clamp the stored count
               msg_in   = cmp_idx_ff;
               sig_in   = '0;
               count_in = (CNT_W'(msg_rd.total) > CNT_W'(MAX_SIGNALS)) ?
                          CNT_W'(MAX_SIGNALS) : CNT_W'(msg_rd.total);
               if (msg_rd.total == '0) begin
                  none_found_in = 1'b1;
                  state_in      = ST_NONE;
               end else begin
                  sig_rd_en  = 1'b1;
                  sig_rd_msg = cmp_idx_ff;
                  sig_rd_num = '0;
                  state_in   = ST_EXTRACT;
               end
            end else if (srch_ff < limit) begin
               msg_rd_en  = 1'b1;
               pend_in    = 1'b1;
               cmp_idx_in = srch_ff[MSG_AW-1:0];
               srch_in    = srch_ff + MSG_CW'(1);
            end else if (!pend_ff || (msg_rd.id != id_ff)) begin
               none_found_in = 1'b0;
               state_in      = ST_NONE;
            end
         end
         ST_NONE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EXTRACT: begin
            raw_in   = extracted;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            prod_in  = mul_p;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            prod_in  = mul_p;
            acc_in   = ACC_W'(prod_ff) + ACC_W'($signed(sig_rd.bias));
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = acc_ff + (ACC_W'(prod_ff) <<< 32);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (last_sig) begin
                  state_in = ST_IDLE;
               end else begin
                  // fetch the next signal entry while this result goes out
                  sig_in     = sig_ff + CNT_W'(1);
                  sig_rd_en  = 1'b1;
                  sig_rd_num = SIG_AW'(sig_ff + CNT_W'(1));
                  state_in   = ST_EXTRACT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_use_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            in_use_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      srch_ff       <= srch_in;
      cmp_idx_ff    <= cmp_idx_in;
      msg_ff        <= msg_in;
      count_ff      <= count_in;
      sig_ff        <= sig_in;
      none_found_ff <= none_found_in;
      raw_ff        <= raw_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      if (req_accept) begin
         id_ff    <= frame_id;
         frame_ff <= frame_data;
      end
      if (rsp_load) begin
         if (state_ff == ST_NONE) begin
            rsp_found_ff  <= none_found_ff;
            rsp_has_ff    <= 1'b0;
            rsp_signum_ff <= '0;
            rsp_raw_ff    <= '0;
            rsp_phys_ff   <= '0;
            rsp_ovf_ff    <= 1'b0;
            rsp_last_ff   <= 1'b1;
         end else begin
            rsp_found_ff  <= 1'b1;
            rsp_has_ff    <= 1'b1;
            rsp_signum_ff <= sig_ff[SIGNUM_W-1:0];
            rsp_raw_ff    <= raw_ff;
            rsp_phys_ff   <= phys;
            rsp_ovf_ff    <= sat;
            rsp_last_ff   <= last_sig;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_has_ff, rsp_found_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - RSP_OVF_LSB - 1){1'b0}}, rsp_ovf_ff,
                        rsp_phys_ff, rsp_raw_ff, rsp_signum_ff};

   a_decode_busy: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (func == FUNC_DECODE)) |=> !req_tready)
      else $error("ready stayed high after a decode was accepted");

   a_signal_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tuser[0])
      else $error("signal result without a matching message");

   a_plain_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[1]) |-> rsp_tlast)
      else $error("result without a signal is not the last one");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (srch_ff <= limit))
      else $error("message search ran past the entries in use");

   a_signal_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EXTRACT) || (state_ff == ST_EMIT)) |-> (sig_ff < count_ff))
      else $error("signal index ran past the signal count");

endmodule

/* verif/can_signal_decoder_core_tb.sv */
`timescale 1ns / 1ps

module can_signal_decoder_core_tb;
   import cansd_pkg::*;

   localparam int CLK_PERIOD     = 12;
   localparam int RESET_CYCLES   = 11;
   localparam int DRAIN_CYCLES   = 200;
   localparam int HOLD_CYCLES    = 500;
   localparam int TIMEOUT_CYCLES = 600000;
   localparam int NUM_MSG        = DEF_MAX_MESSAGES;
   localparam int NUM_SIG        = DEF_MAX_SIGNALS;

   typedef struct {
      func_type            func;
      logic [5:0]          mslot;
      logic [3:0]          sslot;
      logic [ID_W-1:0]     id;
      logic [TOTAL_W-1:0]  total;
      logic [DATA_W-1:0]   data;
      logic [START_W-1:0]  start;
      logic [LENGTH_W-1:0] length;
      logic                big;
      logic [GAIN_W-1:0]   gain;
      logic [BIAS_W-1:0]   bias;
   } frame_item_type;

   typedef struct packed {
      logic                found;
      logic                has_signal;
      logic [SIGNUM_W-1:0] signal_number;
      logic [63:0]         raw_field;
      logic [63:0]         physical_value;
      logic                overflowed;
      logic                last;
   } signal_result_type;

   logic                     clock;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [1:0]               req_tuser   = '0;
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_USER_BITS-1:0] rsp_tuser;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_wr_en   = 1'b0;
   logic [CSR_W-1:0]         csr_wr_data = '0;

   // stimulus side: items waiting for the driver and the generator's view of the tables
   frame_item_type   pending_frames[$];
   frame_item_type   cur_item;
   bit [ID_W-1:0]    gen_ids[NUM_MSG];
   bit [TOTAL_W-1:0] gen_counts[NUM_MSG];
   bit               gen_sig_written[NUM_MSG*NUM_SIG];
   int               gen_in_use = 0;

   // predictor state
   msg_entry_type     msg_table[NUM_MSG];
   sig_entry_type     sig_table[NUM_MSG*NUM_SIG];
   logic [CSR_W-1:0]  pred_in_use = '0;
   signal_result_type awaited_signals[$];

   bit req_taken    = 1'b0;
   int frames_sent  = 0;
   int rsp_count    = 0;
   int mismatches   = 0;
   int hold_left    = 0;
   bit hold_done    = 1'b0;

   can_signal_decoder_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [REQ_DATA_BITS-1:0] pack_request(frame_item_type it);
      logic [REQ_DATA_BITS-1:0] d;
      d = '0;
      d[REQ_MSLOT_LSB +: 6]         = it.mslot;
      d[REQ_SSLOT_LSB +: 4]         = it.sslot;
      d[REQ_ID_LSB +: ID_W]         = it.id;
      d[REQ_TOTAL_LSB +: TOTAL_W]   = it.total;
      d[REQ_DATA_LSB +: DATA_W]     = it.data;
      d[REQ_START_LSB +: START_W]   = it.start;
      d[REQ_LENGTH_LSB +: LENGTH_W] = it.length;
      d[REQ_BIG_LSB]                = it.big;
      d[REQ_GAIN_LSB +: GAIN_W]     = it.gain;
      d[REQ_BIAS_LSB +: BIAS_W]     = it.bias;
      return d;
   endfunction

   function automatic logic [63:0] extract_field(logic [63:0] data, sig_entry_type sig);
      int unsigned len;
      int unsigned shift;
      logic [63:0] mask;
      len  = (sig.length >= 64) ? 64 : sig.length;
      mask = (len == 64) ? '1 : ((64'd1 << len) - 64'd1);
      if (sig.big_endian)
         shift = (sig.start + len >= 64) ? 0 : 64 - (sig.start + len);
      else
         shift = sig.start;
      return (data >> shift) & mask;
   endfunction

   // exact raw * gain + bias, clamped to the signed 64-bit range
   function automatic logic [63:0] scale_value(logic [63:0] raw, logic [31:0] g,
                                               logic [47:0] b, output logic sat);
      logic signed [127:0] prod;
      logic signed [127:0] sum;
      prod = $signed({64'd0, raw}) * $signed({{96{g[31]}}, g});
      sum  = prod + $signed({{80{b[47]}}, b});
      sat  = (sum[127:63] != {65{sum[63]}});
      if (!sat)
         return sum[63:0];
      return sum[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
   endfunction

   task automatic predict_frame(frame_item_type it);
      int unsigned       lim;
      int unsigned       cnt;
      int                hit;
      int                k;
      logic              sat;
      signal_result_type res;
      case (it.func)
         FUNC_WRITE_MSG: msg_table[it.mslot] = '{total: it.total, id: it.id};
         FUNC_WRITE_SIG: sig_table[{it.mslot, it.sslot}] =
            '{bias: it.bias, gain: it.gain, big_endian: it.big,
              length: it.length, start: it.start};
         FUNC_DECODE: begin
            lim = (pred_in_use > NUM_MSG) ? NUM_MSG : pred_in_use;
            hit = -1;
            for (int i = 0; i < lim; i++)
               if (hit < 0 && msg_table[i].id == it.id) hit = i;
            res = '0;
            res.last = 1'b1;
            if (hit < 0) begin
               awaited_signals.push_back(res);
            end else begin
               cnt = (msg_table[hit].total > NUM_SIG) ? NUM_SIG : msg_table[hit].total;
               res.found = 1'b1;
               if (cnt == 0) begin
                  awaited_signals.push_back(res);
               end else begin
                  for (int j = 0; j < cnt; j++) begin
                     k = hit * NUM_SIG + j;
                     res.has_signal     = 1'b1;
                     res.signal_number  = SIGNUM_W'(j);
                     res.raw_field      = extract_field(it.data, sig_table[k]);
                     res.physical_value = scale_value(res.raw_field, sig_table[k].gain,
                                                      sig_table[k].bias, sat);
                     res.overflowed     = sat;
                     res.last           = (j + 1 == cnt);
                     awaited_signals.push_back(res);
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // ---------------- stimulus generation ----------------

   function automatic frame_item_type random_item();
      frame_item_type it;
      it.func   = func_type'($urandom_range(0, 3));
      it.mslot  = 6'($urandom);
      it.sslot  = 4'($urandom);
      it.id     = ID_W'($urandom);
      it.total  = TOTAL_W'($urandom);
      it.data   = {$urandom, $urandom};
      it.start  = START_W'($urandom);
      it.length = LENGTH_W'($urandom);
      it.big    = 1'($urandom);
      it.gain   = $urandom;
      it.bias   = BIAS_W'({$urandom, $urandom});
      return it;
   endfunction

   function automatic logic [63:0] pick_data();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic queue_item(frame_item_type it);
      pending_frames.push_back(it);
      if (it.func == FUNC_WRITE_MSG) begin
         gen_ids[it.mslot]    = it.id;
         gen_counts[it.mslot] = it.total;
      end else if (it.func == FUNC_WRITE_SIG) begin
         gen_sig_written[{it.mslot, it.sslot}] = 1'b1;
      end
   endtask

   task automatic queue_msg_write(int slot, logic [ID_W-1:0] id, logic [TOTAL_W-1:0] total);
      frame_item_type it;
      it       = random_item();
      it.func  = FUNC_WRITE_MSG;
      it.mslot = 6'(slot);
      it.id    = id;
      it.total = total;
      queue_item(it);
   endtask

   task automatic queue_sig_write(int mslot, int sslot, logic [START_W-1:0] start,
                                  logic [LENGTH_W-1:0] length, logic big,
                                  logic [GAIN_W-1:0] gain, logic [BIAS_W-1:0] bias);
      frame_item_type it;
      it        = random_item();
      it.func   = FUNC_WRITE_SIG;
      it.mslot  = 6'(mslot);
      it.sslot  = 4'(sslot);
      it.start  = start;
      it.length = length;
      it.big    = big;
      it.gain   = gain;
      it.bias   = bias;
      queue_item(it);
   endtask

   task automatic queue_random_sig_write(int mslot, int sslot);
      logic [LENGTH_W-1:0] len;
      logic [GAIN_W-1:0]   g;
      logic [BIAS_W-1:0]   b;
      case ($urandom_range(0, 9))
         0:       len = '0;
         1:       len = LENGTH_W'(64);
         2:       len = LENGTH_W'($urandom_range(65, 127));
         default: len = LENGTH_W'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 5))
         0:       g = $urandom;
         1:       g = 32'h7FFF_FFFF;
         2:       g = 32'h8000_0000;
         3:       g = 32'h0001_0000;
         default: begin
            g = $urandom_range(0, 32'h3_FFFF);
            if ($urandom_range(0, 1)) g = -g;
         end
      endcase
      case ($urandom_range(0, 4))
         0:       b = BIAS_W'({$urandom, $urandom});
         1:       b = 48'h7FFF_FFFF_FFFF;
         2:       b = 48'h8000_0000_0000;
         default: begin
            b = BIAS_W'($urandom_range(0, 32'hFF_FFFF));
            if ($urandom_range(0, 1)) b = -b;
         end
      endcase
      queue_sig_write(mslot, sslot, START_W'($urandom), len, 1'($urandom_range(0, 1)), g, b);
   endtask

   // fill in any signal entry the decode will read before queuing the decode
   task automatic queue_decode(logic [ID_W-1:0] id, logic [63:0] data);
      frame_item_type it;
      int             lim;
      int             hit;
      int             cnt;
      lim = (gen_in_use > NUM_MSG) ? NUM_MSG : gen_in_use;
      hit = -1;
      for (int i = 0; i < lim; i++)
         if (hit < 0 && gen_ids[i] == id) hit = i;
      if (hit >= 0) begin
         cnt = (gen_counts[hit] > NUM_SIG) ? NUM_SIG : gen_counts[hit];
         for (int j = 0; j < cnt; j++)
            if (!gen_sig_written[hit * NUM_SIG + j]) queue_random_sig_write(hit, j);
      end
      it      = random_item();
      it.func = FUNC_DECODE;
      it.id   = id;
      it.data = data;
      queue_item(it);
   endtask

   task automatic run_random_items(int n);
      frame_item_type it;
      int             lim;
      int             r;
      int             done;
      done = 0;
      while (done < n) begin
         lim = (gen_in_use > NUM_MSG) ? NUM_MSG : gen_in_use;
         r   = $urandom_range(0, 99);
         done++;
         if (r < 60 && lim > 0) begin
            queue_decode(gen_ids[$urandom_range(0, lim - 1)], pick_data());
         end else if (r < 70) begin
            queue_decode(ID_W'($urandom), pick_data());
         end else if (r < 80) begin
            queue_random_sig_write($urandom_range(0, NUM_MSG - 1), $urandom_range(0, NUM_SIG - 1));
         end else if (r < 90) begin
            queue_msg_write($urandom_range(0, NUM_MSG - 1),
                            $urandom_range(0, 1) ? gen_ids[$urandom_range(0, NUM_MSG - 1)]
                                                 : ID_W'($urandom),
                            ($urandom_range(0, 3) == 0) ? TOTAL_W'($urandom_range(5, 31))
                                                        : TOTAL_W'($urandom_range(0, 4)));
         end else begin
            // ignored selector; does not count as work
            it      = random_item();
            it.func = FUNC_UNUSED;
            queue_item(it);
            done--;
         end
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_frames.size() != 0 || req_tvalid || awaited_signals.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_in_use(int v);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CSR_W'(v);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      gen_in_use = v;
   endtask

   // ---------------- driver and monitors ----------------

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_frames.size() != 0 &&
             ((frames_sent >= 80 && frames_sent < 140) || $urandom_range(0, 99) >= 8)) begin
            cur_item = pending_frames.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= cur_item.func;
            req_tdata  <= pack_request(cur_item);
            frames_sent++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && rsp_count >= 40 && pending_frames.size() > 5) begin
         // hold off long enough for the block to back up into its input
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (rsp_count >= 60 && rsp_count < 120) || $urandom_range(0, 99) >= 8;
      end
   end

   always @(posedge clock) begin
      req_taken = req_tvalid && req_tready;
      if (reset) begin
         pred_in_use = '0;
      end else begin
         if (csr_wr_en) pred_in_use = csr_wr_data;
         if (req_taken) predict_frame(cur_item);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      signal_result_type got;
      signal_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         got.found          = rsp_tuser[0];
         got.has_signal     = rsp_tuser[1];
         got.signal_number  = rsp_tdata[RSP_SIGNUM_LSB +: SIGNUM_W];
         got.raw_field      = rsp_tdata[RSP_RAW_LSB +: 64];
         got.physical_value = rsp_tdata[RSP_PHYS_LSB +: 64];
         got.overflowed     = rsp_tdata[RSP_OVF_LSB];
         got.last           = rsp_tlast;
         if (awaited_signals.size() == 0) begin
            $error("result item with no decode pending: found=%0d raw=0x%0h",
                   got.found, got.raw_field);
            mismatches++;
         end else begin
            want = awaited_signals.pop_front();
            check_field("found", want.found, got.found);
            check_field("has_signal", want.has_signal, got.has_signal);
            check_field("signal_number", want.signal_number, got.signal_number);
            check_field("raw_field", want.raw_field, got.raw_field);
            check_field("physical_value", want.physical_value, got.physical_value);
            check_field("overflowed", want.overflowed, got.overflowed);
            check_field("last", want.last, got.last);
         end
      end
   end

   // ---------------- test sequence ----------------

   initial begin
      frame_item_type      it;
      logic [TOTAL_W-1:0]  total;
      logic [ID_W-1:0]     id;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // nothing in use: any identifier misses
      queue_decode(ID_W'($urandom), pick_data());

      // fill the whole message table; slot 40 repeats the identifier of slot 3, which wins
      for (int s = 0; s < NUM_MSG; s++) begin
         case (s)
            0:       total = TOTAL_W'(0);
            1:       total = TOTAL_W'(16);
            2:       total = TOTAL_W'(31);
            3:       total = TOTAL_W'(2);
            40:      total = TOTAL_W'(3);
            default: total = TOTAL_W'($urandom_range(0, 4));
         endcase
         if (s == 40)      id = gen_ids[3];
         else if (s == 62) id = '0;
         else if (s == 63) id = '1;
         else              id = ID_W'($urandom);
         queue_msg_write(s, id, total);
      end
      set_in_use(NUM_MSG);

      queue_sig_write(1, 0, 0, 64, 1'b0, 32'h7FFF_FFFF, 48'h0);
      queue_sig_write(1, 1, 0, 64, 1'b1, 32'h8000_0000, 48'h8000_0000_0000);
      queue_sig_write(1, 2, 17, 0, 1'b0, $urandom, 48'h7FFF_FFFF_FFFF);
      queue_sig_write(1, 3, 63, 127, 1'b0, 32'h0001_0000, 48'h0);
      queue_sig_write(1, 4, 60, 10, 1'b1, 32'h0000_8000, 48'h1234);
      queue_sig_write(1, 5, 8, 12, 1'b1, 32'h0001_0000, -48'sh1_0000);
      queue_sig_write(1, 6, 63, 1, 1'b0, 32'hFFFF_0000, 48'h0);

      queue_decode(gen_ids[0], pick_data());
      queue_decode(gen_ids[1], '1);
      queue_decode(gen_ids[1], '0);
      queue_decode(gen_ids[1], {$urandom, $urandom});
      queue_decode(gen_ids[2], {$urandom, $urandom});
      queue_decode(gen_ids[40], {$urandom, $urandom});
      queue_decode(gen_ids[63], '1);
      queue_decode(gen_ids[62], {$urandom, $urandom});
      it      = random_item();
      it.func = FUNC_UNUSED;
      queue_item(it);
      queue_decode(ID_W'($urandom), pick_data());
      queue_msg_write(5, ID_W'($urandom), '0);
      queue_decode(gen_ids[5], pick_data());

      // searching beyond the table size clamps to the table
      set_in_use(127);
      queue_decode(gen_ids[63], pick_data());
      queue_decode(ID_W'($urandom), pick_data());
      run_random_items(6);

      set_in_use(NUM_MSG);
      run_random_items(6);

      set_in_use($urandom_range(2, NUM_MSG - 1));
      run_random_items(5);

      set_in_use(1);
      run_random_items(3);

      set_in_use(0);
      queue_decode(gen_ids[0], pick_data());
      queue_decode(ID_W'($urandom), pick_data());

      wait_drained();
      if (mismatches == 0 && awaited_signals.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* sim.f */
sv/cansd_pkg.sv
sv/cansd_ram.sv
sv/can_signal_decoder_core.sv
verif/can_signal_decoder_core_tb.sv
